FILE: hw/rtl/mnt_pkg.sv
// shared types and constants of the mesh node table
package mnt_pkg;

    localparam int ID_W     = 64;
    localparam int ADDR_W   = 16;
    localparam int CNT_W    = 8;
    localparam int ONOFF_W  = 8;
    localparam int COLOUR_W = 16;
    localparam int STATUS_W = 2;
    localparam int SLOT_W   = 4;

    localparam int IN_DATA_W  = 160;
    localparam int OUT_DATA_W = 216;
    localparam int OUT_PAD_W  = 2;

    localparam logic [COLOUR_W-1:0] COLOUR_INIT = 16'd16000;

    localparam logic OP_STORE  = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_INVALID   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL_MISS = 2'd2;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_SCAN,
        FSM_WAIT
    } fsm_t;

    typedef struct packed {
        logic [ID_W-1:0]    id_hi;
        logic [ID_W-1:0]    id_lo;
        logic [ADDR_W-1:0]  base;
        logic [CNT_W-1:0]   count;
        logic [ONOFF_W-1:0] onoff;
    } entry_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot;
        logic [ID_W-1:0]     id_hi;
        logic [ID_W-1:0]     id_lo;
        logic [ADDR_W-1:0]   base;
        logic [CNT_W-1:0]    count;
        logic [ONOFF_W-1:0]  onoff;
        logic [COLOUR_W-1:0] hue;
        logic [COLOUR_W-1:0] saturation;
        logic [COLOUR_W-1:0] lightness;
    } result_t;

endpackage

FILE: hw/rtl/mesh_node_table.sv
// mesh node table: store node records by device id, look up by unicast address
//
//  channel | dir | tdata                                   | tuser
//  s_      | in  | id_high, id_low, address, count, onoff  | opcode (0 store, 1 lookup)
//  m_      | out | status, slot, entry fields, colours     | -
//
// one request is taken at a time; the table is scanned one entry per cycle through a
// registered memory read port, the scan ending early at the first hit.
// a store finds an id match and the first free entry in the same pass.
// reset clears the valid bits of all entries at once; an entry never written reads as zero.
// a finished result waits in a holding register while the output register is stalled.
module mesh_node_table #(
    parameter int TABLE_ENTRIES = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // id_high, id_low, address, element_count, onoff_value
    input  logic [mnt_pkg::IN_DATA_W-1:0]   s_tdata,
    // opcode
    input  logic                            s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // status, slot, entry_id_high, entry_id_low, entry_base, entry_count,
    // entry_onoff, entry_hue, entry_saturation, entry_lightness, zero pad
    output logic [mnt_pkg::OUT_DATA_W-1:0]  m_tdata
);

    localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam logic [IW-1:0] LAST = IW'(TABLE_ENTRIES - 1);

    mnt_pkg::fsm_t state_reg, state_next;

    logic                          op_reg, op_next;
    logic [mnt_pkg::ID_W-1:0]      id_hi_reg, id_hi_next;
    logic [mnt_pkg::ID_W-1:0]      id_lo_reg, id_lo_next;
    logic [mnt_pkg::ADDR_W-1:0]    addr_reg, addr_next;
    logic [mnt_pkg::CNT_W-1:0]     cnt_reg, cnt_next;
    logic [mnt_pkg::ONOFF_W-1:0]   onoff_reg, onoff_next;

    logic [IW-1:0] idx_reg, idx_next;
    logic          issue_en_reg, issue_en_next;
    logic [IW-1:0] cmp_idx_reg, cmp_idx_next;
    logic          cmp_live_reg, cmp_live_next;
    logic [IW-1:0] free_idx_reg, free_idx_next;
    logic          free_found_reg, free_found_next;

    mnt_pkg::entry_t              mem [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0]     valid_reg;
    mnt_pkg::entry_t              rd_data_reg;
    logic                         rd_vld_reg;

    mnt_pkg::result_t res_reg, res_next;
    mnt_pkg::result_t out_reg, out_next;
    logic             m_tvalid_reg, m_tvalid_next;

    logic            wr_en;
    logic [IW-1:0]   wr_idx;
    mnt_pkg::entry_t wr_data;

    mnt_pkg::entry_t            ent;
    logic                       id_hit;
    logic                       is_free;
    logic                       rng_hit;
    logic                       last_cmp;
    logic [mnt_pkg::ADDR_W:0]   end_sum;
    logic [mnt_pkg::ADDR_W-1:0] in_addr;
    logic                       in_unicast;
    logic [IW-1:0]              sel_idx;

    // low slot bits of an entry index, zero extended for small tables
    function automatic logic [mnt_pkg::SLOT_W-1:0] slot_of(input logic [IW-1:0] i);
        logic [mnt_pkg::SLOT_W+IW-1:0] wide;
        wide = {{mnt_pkg::SLOT_W{1'b0}}, i};
        return wide[mnt_pkg::SLOT_W-1:0];
    endfunction

    assign ent      = rd_vld_reg ? rd_data_reg : '0;
    assign id_hit   = (ent.id_hi == id_hi_reg) && (ent.id_lo == id_lo_reg);
    assign is_free  = (ent.base == '0);
    assign end_sum  = {1'b0, ent.base} + {{(mnt_pkg::ADDR_W + 1 - mnt_pkg::CNT_W){1'b0}}, ent.count};
    assign rng_hit  = (ent.base <= addr_reg) && (end_sum > {1'b0, addr_reg});
    assign last_cmp = (cmp_idx_reg == LAST);

    assign in_addr    = s_tdata[143:128];
    assign in_unicast = (in_addr != '0) && !in_addr[mnt_pkg::ADDR_W-1];

    assign wr_data = '{id_hi: id_hi_reg, id_lo: id_lo_reg, base: addr_reg,
                       count: cnt_reg, onoff: onoff_reg};

    always_comb begin
        state_next      = state_reg;
        op_next         = op_reg;
        id_hi_next      = id_hi_reg;
        id_lo_next      = id_lo_reg;
        addr_next       = addr_reg;
        cnt_next        = cnt_reg;
        onoff_next      = onoff_reg;
        idx_next        = idx_reg;
        issue_en_next   = issue_en_reg;
        cmp_idx_next    = cmp_idx_reg;
        cmp_live_next   = 1'b0;
        free_idx_next   = free_idx_reg;
        free_found_next = free_found_reg;
        res_next        = res_reg;
        out_next        = out_reg;
        m_tvalid_next   = m_tvalid_reg;
        wr_en           = 1'b0;
        wr_idx          = cmp_idx_reg;
        sel_idx         = free_found_reg ? free_idx_reg : cmp_idx_reg;
        s_tready        = 1'b0;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            mnt_pkg::FSM_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    op_next    = s_tuser;
                    id_hi_next = s_tdata[63:0];
                    id_lo_next = s_tdata[127:64];
                    addr_next  = in_addr;
                    cnt_next   = s_tdata[151:144];
                    onoff_next = s_tdata[159:152];
                    if (!in_unicast) begin
                        res_next        = '0;
                        res_next.status = mnt_pkg::ST_INVALID;
                        state_next      = mnt_pkg::FSM_WAIT;
                    end else begin
                        idx_next        = '0;
                        issue_en_next   = 1'b1;
                        free_found_next = 1'b0;
                        state_next      = mnt_pkg::FSM_SCAN;
                    end
                end
            end

            mnt_pkg::FSM_SCAN: begin
                // read port runs one entry ahead of the compare
                if (issue_en_reg) begin
                    cmp_idx_next  = idx_reg;
                    cmp_live_next = 1'b1;
                    if (idx_reg == LAST) begin
                        issue_en_next = 1'b0;
                    end else begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
                if (cmp_live_reg) begin
                    if (op_reg == mnt_pkg::OP_LOOKUP) begin
                        priority if (rng_hit) begin
                            res_next = '{status: mnt_pkg::ST_OK, slot: slot_of(cmp_idx_reg),
                                         id_hi: ent.id_hi, id_lo: ent.id_lo, base: ent.base,
                                         count: ent.count, onoff: ent.onoff,
                                         hue: mnt_pkg::COLOUR_INIT,
                                         saturation: mnt_pkg::COLOUR_INIT,
                                         lightness: mnt_pkg::COLOUR_INIT};
                            state_next = mnt_pkg::FSM_WAIT;
                        end else if (last_cmp) begin
                            res_next        = '0;
                            res_next.status = mnt_pkg::ST_FULL_MISS;
                            state_next      = mnt_pkg::FSM_WAIT;
                        end else begin
                            // keep scanning
                            state_next = mnt_pkg::FSM_SCAN;
                        end
                    end else begin
                        if (is_free && !free_found_reg) begin
                            free_found_next = 1'b1;
                            free_idx_next   = cmp_idx_reg;
                        end
                        priority if (id_hit) begin
                            wr_en  = 1'b1;
                            wr_idx = cmp_idx_reg;
                        end else if (last_cmp && (free_found_reg || is_free)) begin
                            wr_en  = 1'b1;
                            wr_idx = sel_idx;
                        end else begin
                            wr_en = 1'b0;
                        end
                        if (wr_en) begin
                            res_next = '{status: mnt_pkg::ST_OK, slot: slot_of(wr_idx),
                                         id_hi: id_hi_reg, id_lo: id_lo_reg, base: addr_reg,
                                         count: cnt_reg, onoff: onoff_reg,
                                         hue: mnt_pkg::COLOUR_INIT,
                                         saturation: mnt_pkg::COLOUR_INIT,
                                         lightness: mnt_pkg::COLOUR_INIT};
                            state_next = mnt_pkg::FSM_WAIT;
                        end else if (last_cmp) begin
                            res_next        = '0;
                            res_next.status = mnt_pkg::ST_FULL_MISS;
                            state_next      = mnt_pkg::FSM_WAIT;
                        end
                    end
                end
            end

            mnt_pkg::FSM_WAIT: begin
                if (!m_tvalid_reg || m_tready) begin
                    out_next      = res_reg;
                    m_tvalid_next = 1'b1;
                    state_next    = mnt_pkg::FSM_IDLE;
                end
            end

            default: begin
                state_next = mnt_pkg::FSM_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= mnt_pkg::FSM_IDLE;
            issue_en_reg   <= 1'b0;
            cmp_live_reg   <= 1'b0;
            free_found_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
            valid_reg      <= '0;
        end else begin
            state_reg      <= state_next;
            issue_en_reg   <= issue_en_next;
            cmp_live_reg   <= cmp_live_next;
            free_found_reg <= free_found_next;
            m_tvalid_reg   <= m_tvalid_next;
            if (wr_en) begin
                valid_reg[wr_idx] <= 1'b1;
            end
        end
    end

    // request and result payload
    always_ff @(posedge aclk) begin
        op_reg       <= op_next;
        id_hi_reg    <= id_hi_next;
        id_lo_reg    <= id_lo_next;
        addr_reg     <= addr_next;
        cnt_reg      <= cnt_next;
        onoff_reg    <= onoff_next;
        idx_reg      <= idx_next;
        cmp_idx_reg  <= cmp_idx_next;
        free_idx_reg <= free_idx_next;
        res_reg      <= res_next;
        out_reg      <= out_next;
    end

    // entry memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_idx] <= wr_data;
        end
        rd_data_reg <= mem[idx_reg];
        rd_vld_reg  <= valid_reg[idx_reg];
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{mnt_pkg::OUT_PAD_W{1'b0}},
                       out_reg.lightness, out_reg.saturation, out_reg.hue,
                       out_reg.onoff, out_reg.count, out_reg.base,
                       out_reg.id_lo, out_reg.id_hi, out_reg.slot, out_reg.status};

endmodule

FILE: dv/mnt_checker.sv
// checker for the mesh node table: predicts each result from accepted requests and compares
module mnt_checker #(
    parameter int TABLE_ENTRIES = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [mnt_pkg::IN_DATA_W-1:0]   s_tdata,
    input  logic                            s_tuser,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [mnt_pkg::OUT_DATA_W-1:0]  m_tdata,
    output int                              fail_count,
    output int                              pending
);

    logic [mnt_pkg::ID_W-1:0]     node_id_hi     [TABLE_ENTRIES];
    logic [mnt_pkg::ID_W-1:0]     node_id_lo     [TABLE_ENTRIES];
    logic [mnt_pkg::ADDR_W-1:0]   node_base      [TABLE_ENTRIES];
    logic [mnt_pkg::CNT_W-1:0]    node_count     [TABLE_ENTRIES];
    logic [mnt_pkg::ONOFF_W-1:0]  node_onoff     [TABLE_ENTRIES];
    logic [mnt_pkg::COLOUR_W-1:0] node_hue       [TABLE_ENTRIES];
    logic [mnt_pkg::COLOUR_W-1:0] node_saturation[TABLE_ENTRIES];
    logic [mnt_pkg::COLOUR_W-1:0] node_lightness [TABLE_ENTRIES];

    mnt_pkg::result_t expected_entries[$];

    initial begin
        fail_count = 0;
        pending = 0;
    end

    // applies one request to the table copy and returns the entry it reports
    function automatic mnt_pkg::result_t serve_request(
            input logic op,
            input logic [mnt_pkg::ID_W-1:0] idh,
            input logic [mnt_pkg::ID_W-1:0] idl,
            input logic [mnt_pkg::ADDR_W-1:0] addr,
            input logic [mnt_pkg::CNT_W-1:0] cnt,
            input logic [mnt_pkg::ONOFF_W-1:0] onoff);
        mnt_pkg::result_t r;
        int hit;
        logic [mnt_pkg::ADDR_W:0] range_end;
        r = '0;
        hit = -1;
        if (addr == '0 || addr > 16'h7FFF) begin
            r.status = mnt_pkg::ST_INVALID;
            return r;
        end
        if (op == mnt_pkg::OP_STORE) begin
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                if (hit < 0 && node_id_hi[i] == idh && node_id_lo[i] == idl)
                    hit = i;
            end
            // no id match: take the first entry that was never written
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                if (hit < 0 && node_base[i] == '0) begin
                    hit = i;
                    node_id_hi[i] = idh;
                    node_id_lo[i] = idl;
                end
            end
            if (hit < 0) begin
                r.status = mnt_pkg::ST_FULL_MISS;
                return r;
            end
            node_base[hit]       = addr;
            node_count[hit]      = cnt;
            node_onoff[hit]      = onoff;
            node_hue[hit]        = mnt_pkg::COLOUR_INIT;
            node_saturation[hit] = mnt_pkg::COLOUR_INIT;
            node_lightness[hit]  = mnt_pkg::COLOUR_INIT;
        end else begin
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                range_end = {1'b0, node_base[i]}
                          + {{(mnt_pkg::ADDR_W + 1 - mnt_pkg::CNT_W){1'b0}}, node_count[i]};
                if (hit < 0 && node_base[i] <= addr && range_end > {1'b0, addr})
                    hit = i;
            end
            if (hit < 0) begin
                r.status = mnt_pkg::ST_FULL_MISS;
                return r;
            end
        end
        r.status     = mnt_pkg::ST_OK;
        r.slot       = mnt_pkg::SLOT_W'(hit);
        r.id_hi      = node_id_hi[hit];
        r.id_lo      = node_id_lo[hit];
        r.base       = node_base[hit];
        r.count      = node_count[hit];
        r.onoff      = node_onoff[hit];
        r.hue        = node_hue[hit];
        r.saturation = node_saturation[hit];
        r.lightness  = node_lightness[hit];
        return r;
    endfunction

    function automatic mnt_pkg::result_t unpack_result(
            input logic [mnt_pkg::OUT_DATA_W-1:0] d);
        mnt_pkg::result_t r;
        r.status     = d[1:0];
        r.slot       = d[5:2];
        r.id_hi      = d[69:6];
        r.id_lo      = d[133:70];
        r.base       = d[149:134];
        r.count      = d[157:150];
        r.onoff      = d[165:158];
        r.hue        = d[181:166];
        r.saturation = d[197:182];
        r.lightness  = d[213:198];
        return r;
    endfunction

    task automatic check_field(input string field, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %h got %h", $time, field, want, got);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        mnt_pkg::result_t want;
        mnt_pkg::result_t got;
        if (!aresetn) begin
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                node_id_hi[i]      = '0;
                node_id_lo[i]      = '0;
                node_base[i]       = '0;
                node_count[i]      = '0;
                node_onoff[i]      = '0;
                node_hue[i]        = '0;
                node_saturation[i] = '0;
                node_lightness[i]  = '0;
            end
            expected_entries.delete();
        end else begin
            // compare before queuing, a response never belongs to the request of the same edge
            if (m_tvalid && m_tready) begin
                got = unpack_result(m_tdata);
                if (expected_entries.size() == 0) begin
                    $display("%0t: response with nothing expected, got %h", $time, m_tdata);
                    fail_count++;
                end else begin
                    want = expected_entries.pop_front();
                    check_field("status", 64'(want.status), 64'(got.status));
                    check_field("slot", 64'(want.slot), 64'(got.slot));
                    check_field("entry_id_high", want.id_hi, got.id_hi);
                    check_field("entry_id_low", want.id_lo, got.id_lo);
                    check_field("entry_base", 64'(want.base), 64'(got.base));
                    check_field("entry_count", 64'(want.count), 64'(got.count));
                    check_field("entry_onoff", 64'(want.onoff), 64'(got.onoff));
                    check_field("entry_hue", 64'(want.hue), 64'(got.hue));
                    check_field("entry_saturation", 64'(want.saturation),
                                64'(got.saturation));
                    check_field("entry_lightness", 64'(want.lightness),
                                64'(got.lightness));
                end
            end
            if (s_tvalid && s_tready)
                expected_entries.push_back(serve_request(s_tuser, s_tdata[63:0],
                    s_tdata[127:64], s_tdata[143:128], s_tdata[151:144], s_tdata[159:152]));
        end
        pending = expected_entries.size();
    end

endmodule

FILE: dv/tb_top.sv
// testbench top for the mesh node table: stimulus, flow control and verdict
module tb_top;

    localparam int TABLE_ENTRIES = 16;
    localparam int ID_POOL       = 20;
    localparam int PHASE_ITEMS   = 277;
    localparam int HOLD_CYCLES   = 300;
    localparam int STALL_LIMIT   = 2000;
    localparam int DRAIN_CYCLES  = 40;

    logic                            aclk;
    logic                            aresetn;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [mnt_pkg::IN_DATA_W-1:0]   s_tdata;
    logic                            s_tuser;
    logic                            m_tvalid;
    logic                            m_tready;
    logic [mnt_pkg::OUT_DATA_W-1:0]  m_tdata;

    int fail_count;
    int pending;
    int send_idle;
    int recv_idle;
    int quiet_cycles;
    logic hold_req;

    // node ids reused by stores so that overwrites and a full table both happen
    logic [mnt_pkg::ID_W-1:0]   pool_id_hi[ID_POOL];
    logic [mnt_pkg::ID_W-1:0]   pool_id_lo[ID_POOL];
    logic [mnt_pkg::ADDR_W-1:0] pool_base [ID_POOL];
    logic [mnt_pkg::CNT_W-1:0]  pool_cnt  [ID_POOL];

    mesh_node_table #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    mnt_checker #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial aclk = 1'b0;
    always #2 aclk = ~aclk;

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == STALL_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // response side flow control, with one long hold-off on request
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_req = 1'b0;
            end else begin
                m_tready = ($urandom_range(0, 99) >= recv_idle);
            end
        end
    end

    task automatic send_request(input logic op, input logic [mnt_pkg::ID_W-1:0] idh,
                                input logic [mnt_pkg::ID_W-1:0] idl,
                                input logic [mnt_pkg::ADDR_W-1:0] addr,
                                input logic [mnt_pkg::CNT_W-1:0] cnt,
                                input logic [mnt_pkg::ONOFF_W-1:0] onoff);
        @(negedge aclk);
        while ($urandom_range(0, 99) < send_idle) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = op;
        s_tdata  = {onoff, cnt, addr, idl, idh};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic store_node(input int k, input logic [mnt_pkg::ADDR_W-1:0] addr,
                              input logic [mnt_pkg::CNT_W-1:0] cnt,
                              input logic [mnt_pkg::ONOFF_W-1:0] onoff);
        pool_base[k] = addr;
        pool_cnt[k]  = cnt;
        send_request(mnt_pkg::OP_STORE, pool_id_hi[k], pool_id_lo[k], addr, cnt, onoff);
    endtask

    task automatic lookup_node(input logic [mnt_pkg::ADDR_W-1:0] addr);
        send_request(mnt_pkg::OP_LOOKUP, {$urandom, $urandom}, {$urandom, $urandom}, addr,
                     mnt_pkg::CNT_W'($urandom), mnt_pkg::ONOFF_W'($urandom));
    endtask

    task automatic run_random(input int n);
        int r;
        int k;
        logic [mnt_pkg::ADDR_W-1:0] addr;
        for (int j = 0; j < n; j++) begin
            r = $urandom_range(0, 99);
            k = $urandom_range(0, ID_POOL - 1);
            if ($urandom_range(0, 9) == 0)
                addr = 16'h7FFF;
            else if ($urandom_range(0, 9) == 0)
                addr = 16'h0001;
            else
                addr = mnt_pkg::ADDR_W'($urandom_range(1, 16'h7FFF));
            if (r < 10) begin
                // non-unicast noise on either request kind
                addr = ($urandom_range(0, 1) != 0)
                     ? 16'h0000
                     : mnt_pkg::ADDR_W'($urandom_range(16'h8000, 16'hFFFF));
                send_request(logic'($urandom_range(0, 1)), {$urandom, $urandom},
                             {$urandom, $urandom}, addr, mnt_pkg::CNT_W'($urandom),
                             mnt_pkg::ONOFF_W'($urandom));
            end else if (r < 50) begin
                store_node(k, addr, mnt_pkg::CNT_W'($urandom), mnt_pkg::ONOFF_W'($urandom));
            end else if (r < 55) begin
                send_request(mnt_pkg::OP_STORE, {$urandom, $urandom}, {$urandom, $urandom},
                             addr, mnt_pkg::CNT_W'($urandom), mnt_pkg::ONOFF_W'($urandom));
            end else if (r < 80) begin
                // aim at a known range, one past its end included
                lookup_node(mnt_pkg::ADDR_W'(pool_base[k] + $urandom_range(0, pool_cnt[k])));
            end else begin
                lookup_node(addr);
            end
        end
    endtask

    initial begin
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = mnt_pkg::OP_STORE;
        hold_req     = 1'b0;
        quiet_cycles = 0;
        send_idle    = 17;
        recv_idle    = 63;
        pool_id_hi[0] = '0;
        pool_id_lo[0] = '0;
        pool_id_hi[1] = '1;
        pool_id_lo[1] = '1;
        for (int k = 2; k < ID_POOL; k++) begin
            pool_id_hi[k] = {$urandom, $urandom};
            pool_id_lo[k] = {$urandom, $urandom};
        end
        for (int k = 0; k < ID_POOL; k++) begin
            pool_base[k] = mnt_pkg::ADDR_W'($urandom_range(1, 16'h7FFF));
            pool_cnt[k]  = mnt_pkg::CNT_W'($urandom_range(1, 255));
        end
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed: empty table, non-unicast addresses, extremes, overlap, zero count
        lookup_node(16'h0010);
        send_request(mnt_pkg::OP_STORE, pool_id_hi[5], pool_id_lo[5], 16'h0000, 8'd3, 8'd1);
        send_request(mnt_pkg::OP_STORE, pool_id_hi[5], pool_id_lo[5], 16'h8000, 8'd3, 8'd1);
        lookup_node(16'hFFFF);
        lookup_node(16'h0000);
        store_node(0, 16'h0001, 8'd1, 8'hFF);
        lookup_node(16'h0001);
        store_node(1, 16'h7FFF, 8'hFF, 8'h00);
        lookup_node(16'h7FFF);
        lookup_node(16'h7FFE);
        store_node(2, 16'h0100, 8'd16, 8'h5A);
        store_node(3, 16'h0108, 8'd8, 8'hA5);
        lookup_node(16'h010A);
        lookup_node(16'h010F);
        lookup_node(16'h0110);
        store_node(4, 16'h0200, 8'd0, 8'h33);
        lookup_node(16'h0200);
        store_node(2, 16'h0300, 8'd4, 8'hC3);
        lookup_node(16'h0302);
        store_node(0, 16'h0040, 8'd2, 8'h3C);
        lookup_node(16'h0041);

        run_random(PHASE_ITEMS);
        send_idle = 63;
        recv_idle = 17;
        run_random(PHASE_ITEMS);
        send_idle = 0;
        recv_idle = 0;
        // keep offering while responses are held off so the input backs up
        hold_req = 1'b1;
        run_random(PHASE_ITEMS);

        @(negedge aclk);
        s_tvalid = 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
